// File: rtl/core/cov_pkg.sv
// ----------------------------------------------------------------------------
// cov_pkg: shared types and constants of the cursor overlay compositor
// pattern geometry, opcode and register codes, queue item layout, helpers
// ----------------------------------------------------------------------------
package cov_pkg;

	localparam int PATTERN_SIZE   = 32;
	localparam int MAX_RESOLUTION = 4096;
	localparam int QUEUE_DEPTH    = 2;

	// fixed field widths
	localparam int PIX_W      = 12;
	localparam int CH_W       = 8;
	localparam int RES_W      = 13;
	localparam int HOT_W      = 5;
	localparam int COORD_W    = 14;
	localparam int ROWNUM_W   = 5;
	localparam int ROWIN_W    = 32;
	localparam int SHOW_W     = 16;
	localparam int OPCODE_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// derived widths
	localparam int PAT_W  = PATTERN_SIZE;
	localparam int ROW_W  = $clog2(PATTERN_SIZE);
	localparam int CUR_W  = $clog2(MAX_RESOLUTION);
	localparam int LIM_W  = (CUR_W + 1 > RES_W) ? CUR_W + 1 : RES_W;
	localparam int SUM_W  = ((LIM_W + 1 > COORD_W) ? LIM_W + 1 : COORD_W) + 1;
	localparam int DIFF_W = ((CUR_W > PIX_W) ? CUR_W : PIX_W) + 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CUR_W-1:0] CURSOR_X_RESET = CUR_W'(320);
	localparam logic [CUR_W-1:0] CURSOR_Y_RESET = CUR_W'(240);
	localparam logic [RES_W-1:0] WIDTH_RESET    = RES_W'(640);
	localparam logic [RES_W-1:0] HEIGHT_RESET   = RES_W'(480);

	localparam logic signed [SHOW_W-1:0] SHOW_MAX = 16'sh7fff;
	localparam logic signed [SHOW_W-1:0] SHOW_MIN = 16'sh8000;

	localparam logic [CH_W-1:0] CH_WHITE = 8'hff;
	localparam logic [CH_W-1:0] CH_BLACK = 8'h00;

	localparam int ARROW_ROWS = 16;
	localparam logic [ROWIN_W-1:0] ARROW_DATA [ARROW_ROWS] = '{
		32'hc0000000, 32'ha0000000, 32'h90000000, 32'h88000000,
		32'h84000000, 32'h82000000, 32'h81000000, 32'h80800000,
		32'h83c00000, 32'hb2000000, 32'hd2000000, 32'h89000000,
		32'h09000000, 32'h04800000, 32'h04800000, 32'h03000000
	};
	localparam logic [ROWIN_W-1:0] ARROW_MASK [ARROW_ROWS] = '{
		32'hc0000000, 32'he0000000, 32'hf0000000, 32'hf8000000,
		32'hfc000000, 32'hfe000000, 32'hff000000, 32'hff800000,
		32'hffc00000, 32'hbe000000, 32'hde000000, 32'h8f000000,
		32'h0f000000, 32'h07800000, 32'h07800000, 32'h03000000
	};

	typedef enum logic [OPCODE_W-1:0] {
		OP_PIXEL = 3'd0,
		OP_LOAD  = 3'd1,
		OP_SET   = 3'd2,
		OP_MOVE  = 3'd3,
		OP_SHOW  = 3'd4,
		OP_HIDE  = 3'd5
	} op_code_t;

	typedef enum logic [2:0] {
		KIND_PIXEL,
		KIND_LOAD,
		KIND_SET,
		KIND_MOVE,
		KIND_SHOW,
		KIND_HIDE,
		KIND_NOP
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_WIDTH  = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1,
		REG_HOT_X         = 2'd2,
		REG_HOT_Y         = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [RES_W-1:0] screen_width;
		logic [RES_W-1:0] screen_height;
		logic [HOT_W-1:0] hot_x;
		logic [HOT_W-1:0] hot_y;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic [PIX_W-1:0]   pixel_x;
		logic [PIX_W-1:0]   pixel_y;
		logic [CH_W-1:0]    red;
		logic [CH_W-1:0]    green;
		logic [CH_W-1:0]    blue;
		logic               on_screen;
		logic               row_ok;
		logic [ROW_W-1:0]   row_idx;
		logic [PAT_W-1:0]   row_data;
		logic [PAT_W-1:0]   row_mask;
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
	} item_t;

	// bit 31 of an input row lands on the leftmost pattern column
	function automatic logic [PAT_W-1:0] row_align(input logic [ROWIN_W-1:0] v);
		logic [PAT_W+ROWIN_W-1:0] wide;
		wide = {v, {PAT_W{1'b0}}};
		return wide[PAT_W+ROWIN_W-1 -: PAT_W];
	endfunction

	function automatic logic [PAT_W-1:0] reset_data_row(input int idx);
		logic [3:0] a;
		a = idx[3:0];
		if (idx < ARROW_ROWS) return row_align(ARROW_DATA[a]);
		return '0;
	endfunction

	function automatic logic [PAT_W-1:0] reset_mask_row(input int idx);
		logic [3:0] a;
		a = idx[3:0];
		if (idx < ARROW_ROWS) return row_align(ARROW_MASK[a]);
		return '0;
	endfunction

	// clamp to 0 .. min(res, MAX_RESOLUTION) - 1, zero resolution clamps to 0
	function automatic logic [CUR_W-1:0] clamp_axis(input logic signed [SUM_W-1:0] v,
			input logic [RES_W-1:0] res);
		logic [LIM_W-1:0] lim;
		if (res == '0) begin
			lim = LIM_W'(1);
		end else if (LIM_W'(res) > LIM_W'(MAX_RESOLUTION)) begin
			lim = LIM_W'(MAX_RESOLUTION);
		end else begin
			lim = LIM_W'(res);
		end
		if (v < 0) return '0;
		if (v >= signed'(SUM_W'(lim))) return CUR_W'(lim - LIM_W'(1));
		return CUR_W'(v);
	endfunction

endpackage

// File: rtl/core/cov_front.sv
// ----------------------------------------------------------------------------
// cov_front: input stage of the overlay
// accepts items, decodes the opcode and checks what needs no cursor state
// ----------------------------------------------------------------------------
module cov_front import cov_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [PIX_W-1:0]    pixel_x,
	input  logic [PIX_W-1:0]    pixel_y,
	input  logic [CH_W-1:0]     red_in,
	input  logic [CH_W-1:0]     green_in,
	input  logic [CH_W-1:0]     blue_in,
	input  logic [ROWNUM_W-1:0] row_number,
	input  logic [ROWIN_W-1:0]  row_bits,
	input  logic [ROWIN_W-1:0]  row_enable,
	input  logic [COORD_W-1:0]  coord_x,
	input  logic [COORD_W-1:0]  coord_y,
	input  logic                q_full,
	output logic                push,
	output item_t               push_item
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_d;
	logic  accept;

	assign in_stall  = valid_s1 & q_full;
	assign accept    = in_valid & ~in_stall;
	assign push      = valid_s1 & ~q_full;
	assign push_item = item_s1;

	always_comb begin
		item_d.pixel_x   = pixel_x;
		item_d.pixel_y   = pixel_y;
		item_d.red       = red_in;
		item_d.green     = green_in;
		item_d.blue      = blue_in;
		item_d.on_screen = (RES_W'(pixel_x) < cfg.screen_width) &&
			(RES_W'(pixel_y) < cfg.screen_height);
		item_d.row_ok    = (int'(row_number) < PATTERN_SIZE);
		item_d.row_idx   = ROW_W'(row_number);
		item_d.row_data  = row_align(row_bits);
		item_d.row_mask  = row_align(row_enable);
		item_d.coord_x   = coord_x;
		item_d.coord_y   = coord_y;
		case (op_code_t'(opcode))
			OP_PIXEL: item_d.kind = KIND_PIXEL;
			OP_LOAD:  item_d.kind = KIND_LOAD;
			OP_SET:   item_d.kind = KIND_SET;
			OP_MOVE:  item_d.kind = KIND_MOVE;
			OP_SHOW:  item_d.kind = KIND_SHOW;
			OP_HIDE:  item_d.kind = KIND_HIDE;
			default:  item_d.kind = KIND_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

// File: rtl/core/cov_queue.sv
// ----------------------------------------------------------------------------
// cov_queue: short item queue between front and back
// registered full flag, no fall-through
// ----------------------------------------------------------------------------
module cov_queue import cov_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) return '0;
		return p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: rtl/core/cov_back.sv
// ----------------------------------------------------------------------------
// cov_back: execution stage of the overlay
// holds cursor state and pattern planes, composites pixels, drives results
// ----------------------------------------------------------------------------
module cov_back import cov_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     head_valid,
	input  item_t                    head_item,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [CH_W-1:0]          red_out,
	output logic [CH_W-1:0]          green_out,
	output logic [CH_W-1:0]          blue_out,
	output logic                     covered,
	output logic [CUR_W-1:0]         cursor_x_out,
	output logic [CUR_W-1:0]         cursor_y_out,
	output logic signed [SHOW_W-1:0] visibility_count
);

	logic [CUR_W-1:0]         cursor_x_q;
	logic [CUR_W-1:0]         cursor_y_q;
	logic signed [SHOW_W-1:0] show_q;
	logic [PAT_W-1:0]         pat_data_q [PATTERN_SIZE];
	logic [PAT_W-1:0]         pat_mask_q [PATTERN_SIZE];

	logic                     out_valid_q;
	logic [CH_W-1:0]          red_q;
	logic [CH_W-1:0]          green_q;
	logic [CH_W-1:0]          blue_q;
	logic                     covered_q;
	logic [CUR_W-1:0]         cur_x_out_q;
	logic [CUR_W-1:0]         cur_y_out_q;
	logic signed [SHOW_W-1:0] show_out_q;

	logic [CUR_W-1:0]         cursor_x_d;
	logic [CUR_W-1:0]         cursor_y_d;
	logic signed [SHOW_W-1:0] show_d;
	logic [CH_W-1:0]          red_d;
	logic [CH_W-1:0]          green_d;
	logic [CH_W-1:0]          blue_d;
	logic                     covered_d;

	logic signed [DIFF_W-1:0] col;
	logic signed [DIFF_W-1:0] row;
	logic                     in_pattern;
	logic [ROW_W-1:0]         row_sel;
	logic [ROW_W-1:0]         bit_sel;
	logic                     d_bit;
	logic                     m_bit;
	logic signed [SUM_W-1:0]  abs_x;
	logic signed [SUM_W-1:0]  abs_y;
	logic signed [SUM_W-1:0]  rel_x;
	logic signed [SUM_W-1:0]  rel_y;

	assign pop       = head_valid & (~out_valid_q | ~out_stall);
	assign out_valid = out_valid_q;

	assign red_out          = red_q;
	assign green_out        = green_q;
	assign blue_out         = blue_q;
	assign covered          = covered_q;
	assign cursor_x_out     = cur_x_out_q;
	assign cursor_y_out     = cur_y_out_q;
	assign visibility_count = show_out_q;

	// pattern column and row under the pixel
	assign col = signed'(DIFF_W'(head_item.pixel_x)) - signed'(DIFF_W'(cursor_x_q)) +
		signed'(DIFF_W'(cfg.hot_x));
	assign row = signed'(DIFF_W'(head_item.pixel_y)) - signed'(DIFF_W'(cursor_y_q)) +
		signed'(DIFF_W'(cfg.hot_y));
	assign in_pattern = (col >= 0) && (col < signed'(DIFF_W'(PATTERN_SIZE))) &&
		(row >= 0) && (row < signed'(DIFF_W'(PATTERN_SIZE)));
	assign row_sel = row[ROW_W-1:0];
	assign bit_sel = ROW_W'(PATTERN_SIZE - 1) - col[ROW_W-1:0];
	assign d_bit   = pat_data_q[row_sel][bit_sel];
	assign m_bit   = pat_mask_q[row_sel][bit_sel];

	// sign-extended position operands
	assign abs_x = SUM_W'(signed'(head_item.coord_x));
	assign abs_y = SUM_W'(signed'(head_item.coord_y));
	assign rel_x = signed'(SUM_W'(cursor_x_q)) + abs_x;
	assign rel_y = signed'(SUM_W'(cursor_y_q)) + abs_y;

	always_comb begin
		cursor_x_d = cursor_x_q;
		cursor_y_d = cursor_y_q;
		show_d     = show_q;
		red_d      = '0;
		green_d    = '0;
		blue_d     = '0;
		covered_d  = 1'b0;
		case (head_item.kind)
			KIND_PIXEL: begin
				red_d   = head_item.red;
				green_d = head_item.green;
				blue_d  = head_item.blue;
				if ((show_q > 0) && head_item.on_screen && in_pattern) begin
					if (d_bit && m_bit) begin
						red_d     = CH_BLACK;
						green_d   = CH_BLACK;
						blue_d    = CH_BLACK;
						covered_d = 1'b1;
					end else if (d_bit) begin
						red_d     = ~head_item.red;
						green_d   = ~head_item.green;
						blue_d    = ~head_item.blue;
						covered_d = 1'b1;
					end else if (m_bit) begin
						red_d     = CH_WHITE;
						green_d   = CH_WHITE;
						blue_d    = CH_WHITE;
						covered_d = 1'b1;
					end
				end
			end
			KIND_SET: begin
				cursor_x_d = clamp_axis(abs_x, cfg.screen_width);
				cursor_y_d = clamp_axis(abs_y, cfg.screen_height);
			end
			KIND_MOVE: begin
				cursor_x_d = clamp_axis(rel_x, cfg.screen_width);
				cursor_y_d = clamp_axis(rel_y, cfg.screen_height);
			end
			KIND_SHOW: begin
				if (show_q != SHOW_MAX) show_d = show_q + SHOW_W'(1);
			end
			KIND_HIDE: begin
				if (show_q != SHOW_MIN) show_d = show_q - SHOW_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q  <= CURSOR_X_RESET;
			cursor_y_q  <= CURSOR_Y_RESET;
			show_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < PATTERN_SIZE; i++) begin
				pat_data_q[i] <= reset_data_row(i);
				pat_mask_q[i] <= reset_mask_row(i);
			end
		end else begin
			if (pop) begin
				cursor_x_q  <= cursor_x_d;
				cursor_y_q  <= cursor_y_d;
				show_q      <= show_d;
				out_valid_q <= 1'b1;
				if (head_item.kind == KIND_LOAD && head_item.row_ok) begin
					pat_data_q[head_item.row_idx] <= head_item.row_data;
					pat_mask_q[head_item.row_idx] <= head_item.row_mask;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			red_q       <= red_d;
			green_q     <= green_d;
			blue_q      <= blue_d;
			covered_q   <= covered_d;
			cur_x_out_q <= cursor_x_d;
			cur_y_out_q <= cursor_y_d;
			show_out_q  <= show_d;
		end
	end

endmodule

// File: rtl/core/cursor_overlay_compositor_top.sv
// ----------------------------------------------------------------------------
// cursor_overlay_compositor_top: hardware cursor overlay on a pixel stream
// 32x32 data/mask cursor pattern composited over incoming pixels
// ----------------------------------------------------------------------------
// path: an accepted item passes the front register, a queue slot and the result register
// throughput: one item per cycle while out_stall is low; the back stage executes each
//   item as it pops, against cursor state, so the cursor update loop sets the rate
// reset: 640x480 screen, hotspot 0,0, cursor at 320,240, show count zero,
//   default arrow in the top sixteen pattern rows, pipeline and queue empty
// ----------------------------------------------------------------------------
module cursor_overlay_compositor_top import cov_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration writes
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	// input items
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [OPCODE_W-1:0]      opcode,
	input  logic [PIX_W-1:0]         pixel_x,
	input  logic [PIX_W-1:0]         pixel_y,
	input  logic [CH_W-1:0]          red_in,
	input  logic [CH_W-1:0]          green_in,
	input  logic [CH_W-1:0]          blue_in,
	input  logic [ROWNUM_W-1:0]      row_number,
	input  logic [ROWIN_W-1:0]       row_bits,
	input  logic [ROWIN_W-1:0]       row_enable,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	// result items
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [CH_W-1:0]          red_out,
	output logic [CH_W-1:0]          green_out,
	output logic [CH_W-1:0]          blue_out,
	output logic                     covered,
	output logic [CUR_W-1:0]         cursor_x_out,
	output logic [CUR_W-1:0]         cursor_y_out,
	output logic signed [SHOW_W-1:0] visibility_count
);

	// configuration registers; the user must change them only while the pipe is empty, the block does not enforce it
	cfg_t  cfg_q;

	// front to queue
	logic  push;
	item_t push_item;
	logic  q_full;

	// queue to back
	logic  pop;
	logic  head_valid;
	item_t head_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= WIDTH_RESET;
			cfg_q.screen_height <= HEIGHT_RESET;
			cfg_q.hot_x         <= '0;
			cfg_q.hot_y         <= '0;
		end else if (cfg_write) begin
			case (reg_index_t'(cfg_index))
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[RES_W-1:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[RES_W-1:0];
				REG_HOT_X:         cfg_q.hot_x         <= cfg_data[HOT_W-1:0];
				REG_HOT_Y:         cfg_q.hot_y         <= cfg_data[HOT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// front: take the item, decode opcode, precompute on-screen and row checks
	cov_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.row_number (row_number),
		.row_bits   (row_bits),
		.row_enable (row_enable),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	// decoupling queue so the input side keeps flowing while results stall
	cov_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// back: cursor state, pattern planes, compositing and result register
	cov_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.head_valid       (head_valid),
		.head_item        (head_item),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.red_out          (red_out),
		.green_out        (green_out),
		.blue_out         (blue_out),
		.covered          (covered),
		.cursor_x_out     (cursor_x_out),
		.cursor_y_out     (cursor_y_out),
		.visibility_count (visibility_count)
	);

endmodule

// File: tb/cursor_overlay_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cursor_overlay_checker: shadow model and result comparison
// tracks configuration writes and accepted items, predicts every composited
// result and compares it field by field with what leaves the block
// ----------------------------------------------------------------------------
module cursor_overlay_checker import cov_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [OPCODE_W-1:0]       opcode,
	input  logic [PIX_W-1:0]          pixel_x,
	input  logic [PIX_W-1:0]          pixel_y,
	input  logic [CH_W-1:0]           red_in,
	input  logic [CH_W-1:0]           green_in,
	input  logic [CH_W-1:0]           blue_in,
	input  logic [ROWNUM_W-1:0]       row_number,
	input  logic [ROWIN_W-1:0]        row_bits,
	input  logic [ROWIN_W-1:0]        row_enable,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [CH_W-1:0]           red_out,
	input  logic [CH_W-1:0]           green_out,
	input  logic [CH_W-1:0]           blue_out,
	input  logic                      covered,
	input  logic [CUR_W-1:0]          cursor_x_out,
	input  logic [CUR_W-1:0]          cursor_y_out,
	input  logic signed [SHOW_W-1:0]  visibility_count,
	output int                        mismatch_count,
	output int                        pending_results
);

	typedef struct packed {
		logic [CH_W-1:0]          red;
		logic [CH_W-1:0]          green;
		logic [CH_W-1:0]          blue;
		logic                     cov;
		logic [CUR_W-1:0]         cx;
		logic [CUR_W-1:0]         cy;
		logic signed [SHOW_W-1:0] vis;
	} overlay_out_t;

	// power-on arrow, top sixteen rows, bit 31 is the leftmost column
	localparam logic [31:0] ARROW_PLANE_D [16] = '{
		32'hc0000000, 32'ha0000000, 32'h90000000, 32'h88000000,
		32'h84000000, 32'h82000000, 32'h81000000, 32'h80800000,
		32'h83c00000, 32'hb2000000, 32'hd2000000, 32'h89000000,
		32'h09000000, 32'h04800000, 32'h04800000, 32'h03000000
	};
	localparam logic [31:0] ARROW_PLANE_M [16] = '{
		32'hc0000000, 32'he0000000, 32'hf0000000, 32'hf8000000,
		32'hfc000000, 32'hfe000000, 32'hff000000, 32'hff800000,
		32'hffc00000, 32'hbe000000, 32'hde000000, 32'h8f000000,
		32'h0f000000, 32'h07800000, 32'h07800000, 32'h03000000
	};

	logic [RES_W-1:0]         scr_w, scr_h;
	logic [HOT_W-1:0]         spot_x, spot_y;
	logic [CUR_W-1:0]         cur_x, cur_y;
	logic signed [SHOW_W-1:0] show_lvl;
	logic [31:0]              plane_d [PATTERN_SIZE];
	logic [31:0]              plane_m [PATTERN_SIZE];

	overlay_out_t outputs_due [$];
	overlay_out_t want;
	int           fails = 0;

	assign mismatch_count  = fails;
	assign pending_results = outputs_due.size();

	function automatic void load_power_on_state();
		int r;
		scr_w    = RES_W'(640);
		scr_h    = RES_W'(480);
		spot_x   = '0;
		spot_y   = '0;
		cur_x    = CUR_W'(320);
		cur_y    = CUR_W'(240);
		show_lvl = '0;
		for (r = 0; r < PATTERN_SIZE; r++) begin
			plane_d[r] = (r < 16) ? ARROW_PLANE_D[r] : '0;
			plane_m[r] = (r < 16) ? ARROW_PLANE_M[r] : '0;
		end
	endfunction

	function automatic logic [CUR_W-1:0] limit_to_screen(input int v, input logic [RES_W-1:0] res);
		int lim;
		lim = (int'(res) < MAX_RESOLUTION) ? int'(res) : MAX_RESOLUTION;
		if (lim < 1)
			lim = 1;
		if (v < 0)
			return '0;
		if (v >= lim)
			return CUR_W'(lim - 1);
		return CUR_W'(v);
	endfunction

	// applies one item to the shadow cursor state and returns its result
	function automatic overlay_out_t composite_overlay();
		overlay_out_t res;
		int col, row;
		logic d, m;
		res = '0;
		case (opcode)
			OP_PIXEL: begin
				res.red   = red_in;
				res.green = green_in;
				res.blue  = blue_in;
				if (show_lvl > 0 && int'(pixel_x) < int'(scr_w) && int'(pixel_y) < int'(scr_h)) begin
					col = int'(pixel_x) - (int'(cur_x) - int'(spot_x));
					row = int'(pixel_y) - (int'(cur_y) - int'(spot_y));
					if (col >= 0 && col < PATTERN_SIZE && row >= 0 && row < PATTERN_SIZE) begin
						d = plane_d[row][31 - col];
						m = plane_m[row][31 - col];
						if (d && m) begin
							res.red = 8'h00; res.green = 8'h00; res.blue = 8'h00;
							res.cov = 1'b1;
						end else if (d) begin
							res.red = ~red_in; res.green = ~green_in; res.blue = ~blue_in;
							res.cov = 1'b1;
						end else if (m) begin
							res.red = 8'hff; res.green = 8'hff; res.blue = 8'hff;
							res.cov = 1'b1;
						end
					end
				end
			end
			OP_LOAD: begin
				if (int'(row_number) < PATTERN_SIZE) begin
					plane_d[row_number] = row_bits;
					plane_m[row_number] = row_enable;
				end
			end
			OP_SET: begin
				cur_x = limit_to_screen(int'(coord_x), scr_w);
				cur_y = limit_to_screen(int'(coord_y), scr_h);
			end
			OP_MOVE: begin
				cur_x = limit_to_screen(int'(cur_x) + int'(coord_x), scr_w);
				cur_y = limit_to_screen(int'(cur_y) + int'(coord_y), scr_h);
			end
			OP_SHOW: begin
				if (int'(show_lvl) < 32767)
					show_lvl = show_lvl + 16'sd1;
			end
			OP_HIDE: begin
				if (int'(show_lvl) > -32768)
					show_lvl = show_lvl - 16'sd1;
			end
			default: ;
		endcase
		res.cx  = cur_x;
		res.cy  = cur_y;
		res.vis = show_lvl;
		return res;
	endfunction

	task automatic check_value(input string field, input logic signed [63:0] want_v,
			input logic signed [63:0] got_v);
		if (want_v !== got_v) begin
			fails++;
			if (fails <= 10)
				$display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_power_on_state();
			outputs_due.delete();
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_SCREEN_WIDTH:  scr_w  = cfg_data[RES_W-1:0];
					REG_SCREEN_HEIGHT: scr_h  = cfg_data[RES_W-1:0];
					REG_HOT_X:         spot_x = cfg_data[HOT_W-1:0];
					REG_HOT_Y:         spot_y = cfg_data[HOT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (outputs_due.size() == 0) begin
					check_value("out_valid", 0, 1);
				end else begin
					want = outputs_due.pop_front();
					check_value("red_out", want.red, red_out);
					check_value("green_out", want.green, green_out);
					check_value("blue_out", want.blue, blue_out);
					check_value("covered", want.cov, covered);
					check_value("cursor_x_out", want.cx, cursor_x_out);
					check_value("cursor_y_out", want.cy, cursor_y_out);
					check_value("visibility_count", want.vis, visibility_count);
				end
			end
			if (in_valid && !in_stall)
				outputs_due.push_back(composite_overlay());
		end
	end

endmodule

// File: tb/cursor_overlay_compositor_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cursor_overlay_compositor_top_tb: stimulus and verdict for the cursor overlay
// directed corner items, then random items across several screen and hotspot
// setups and idle patterns; a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module cursor_overlay_compositor_top_tb import cov_pkg::*;;

	// opcodes with no defined function, the block must treat them as no-ops
	localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd7;

	localparam int LIMIT_CYCLES = 60000;
	localparam int PHASE_ITEMS  = 30;

	// screen and hotspot setups for the random part, extremes included
	localparam int SETUPS = 6;
	localparam int SETUP_W  [SETUPS] = '{4096, 1, 40, 8191,    0, 800};
	localparam int SETUP_H  [SETUPS] = '{4096, 1, 36, 8191,    0, 600};
	localparam int SETUP_HX [SETUPS] = '{  31, 0,  5,   31,   12,  16};
	localparam int SETUP_HY [SETUPS] = '{  31, 0, 17,    0,   31,  16};

	logic clk;
	logic arst_n = 1'b0;

	logic                      cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data  = '0;

	logic                      in_valid   = 1'b0;
	logic                      in_stall;
	logic [OPCODE_W-1:0]       opcode     = '0;
	logic [PIX_W-1:0]          pixel_x    = '0;
	logic [PIX_W-1:0]          pixel_y    = '0;
	logic [CH_W-1:0]           red_in     = '0;
	logic [CH_W-1:0]           green_in   = '0;
	logic [CH_W-1:0]           blue_in    = '0;
	logic [ROWNUM_W-1:0]       row_number = '0;
	logic [ROWIN_W-1:0]        row_bits   = '0;
	logic [ROWIN_W-1:0]        row_enable = '0;
	logic signed [COORD_W-1:0] coord_x    = '0;
	logic signed [COORD_W-1:0] coord_y    = '0;

	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [CH_W-1:0]           red_out;
	logic [CH_W-1:0]           green_out;
	logic [CH_W-1:0]           blue_out;
	logic                      covered;
	logic [CUR_W-1:0]          cursor_x_out;
	logic [CUR_W-1:0]          cursor_y_out;
	logic signed [SHOW_W-1:0]  visibility_count;

	int mismatches;
	int pending;

	// staged payload of the next item
	logic [OPCODE_W-1:0]       nx_op;
	logic [PIX_W-1:0]          nx_px, nx_py;
	logic [CH_W-1:0]           nx_r, nx_g, nx_b;
	logic [ROWNUM_W-1:0]       nx_row;
	logic [ROWIN_W-1:0]        nx_bits, nx_enab;
	logic signed [COORD_W-1:0] nx_cx, nx_cy;

	// rough idea of where the cursor is, only used to aim pixels at it
	int aim_x = 320, aim_y = 240;
	int cfg_w = 640, cfg_h = 480, cfg_hx = 0, cfg_hy = 0;

	// idle percentages: sender gap per cycle and receiver stall per cycle
	int send_pct = 0;
	int hold_pct = 0;
	int cycles   = 0;

	cursor_overlay_compositor_top DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.opcode           (opcode),
		.pixel_x          (pixel_x),
		.pixel_y          (pixel_y),
		.red_in           (red_in),
		.green_in         (green_in),
		.blue_in          (blue_in),
		.row_number       (row_number),
		.row_bits         (row_bits),
		.row_enable       (row_enable),
		.coord_x          (coord_x),
		.coord_y          (coord_y),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.red_out          (red_out),
		.green_out        (green_out),
		.blue_out         (blue_out),
		.covered          (covered),
		.cursor_x_out     (cursor_x_out),
		.cursor_y_out     (cursor_y_out),
		.visibility_count (visibility_count)
	);

	cursor_overlay_checker overlay_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.opcode           (opcode),
		.pixel_x          (pixel_x),
		.pixel_y          (pixel_y),
		.red_in           (red_in),
		.green_in         (green_in),
		.blue_in          (blue_in),
		.row_number       (row_number),
		.row_bits         (row_bits),
		.row_enable       (row_enable),
		.coord_x          (coord_x),
		.coord_y          (coord_y),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.red_out          (red_out),
		.green_out        (green_out),
		.blue_out         (blue_out),
		.covered          (covered),
		.cursor_x_out     (cursor_x_out),
		.cursor_y_out     (cursor_y_out),
		.visibility_count (visibility_count),
		.mismatch_count   (mismatches),
		.pending_results  (pending)
	);

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver back-pressure, rate set per phase
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < hold_pct);
	end

	// watchdog, far above the slowest legal run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// stimulus-side clamp, only keeps the aim point near the real cursor
	function automatic int fit_axis(input int v, input int res);
		int lim;
		lim = (res < MAX_RESOLUTION) ? res : MAX_RESOLUTION;
		if (lim < 1)
			lim = 1;
		if (v < 0)
			return 0;
		return (v >= lim) ? lim - 1 : v;
	endfunction

	// random content in every field, callers override what matters
	function automatic void scramble_payload();
		nx_px   = PIX_W'($urandom);
		nx_py   = PIX_W'($urandom);
		nx_r    = CH_W'($urandom);
		nx_g    = CH_W'($urandom);
		nx_b    = CH_W'($urandom);
		nx_row  = ROWNUM_W'($urandom);
		nx_bits = ROWIN_W'($urandom);
		nx_enab = ROWIN_W'($urandom);
		nx_cx   = COORD_W'($urandom);
		nx_cy   = COORD_W'($urandom);
	endfunction

	// present the staged item, hold it through stalls, return at the edge
	// where it is taken; stall is sampled at the falling edge, where it is settled
	task automatic issue();
		logic took;
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= nx_op;
		pixel_x    <= nx_px;
		pixel_y    <= nx_py;
		red_in     <= nx_r;
		green_in   <= nx_g;
		blue_in    <= nx_b;
		row_number <= nx_row;
		row_bits   <= nx_bits;
		row_enable <= nx_enab;
		coord_x    <= nx_cx;
		coord_y    <= nx_cy;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic put_bare(input logic [OPCODE_W-1:0] op);
		scramble_payload();
		nx_op = op;
		issue();
	endtask

	task automatic put_pixel(input int x, input int y, input logic [CH_W-1:0] r,
			input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		scramble_payload();
		nx_op = OP_PIXEL;
		nx_px = PIX_W'(x);
		nx_py = PIX_W'(y);
		nx_r  = r;
		nx_g  = g;
		nx_b  = b;
		issue();
	endtask

	task automatic put_row(input int n, input logic [ROWIN_W-1:0] d, input logic [ROWIN_W-1:0] m);
		scramble_payload();
		nx_op   = OP_LOAD;
		nx_row  = ROWNUM_W'(n);
		nx_bits = d;
		nx_enab = m;
		issue();
	endtask

	// set or move, keeps the aim point in step
	task automatic put_position(input logic [OPCODE_W-1:0] op, input int x, input int y);
		scramble_payload();
		nx_op = op;
		nx_cx = COORD_W'(x);
		nx_cy = COORD_W'(y);
		issue();
		if (op == OP_SET) begin
			aim_x = fit_axis(int'(nx_cx), cfg_w);
			aim_y = fit_axis(int'(nx_cy), cfg_h);
		end else begin
			aim_x = fit_axis(aim_x + int'(nx_cx), cfg_w);
			aim_y = fit_axis(aim_y + int'(nx_cy), cfg_h);
		end
	endtask

	// all four registers, back to back, block idle
	task automatic write_setup(input int w, input int h, input int hx, input int hy);
		reg_index_t regs [4];
		int vals [4];
		int i;
		regs = '{REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, REG_HOT_X, REG_HOT_Y};
		vals = '{w, h, hx, hy};
		for (i = 0; i < 4; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= CFG_DATA_W'(vals[i]);
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		cfg_w  = w;
		cfg_h  = h;
		cfg_hx = hx;
		cfg_hy = hy;
	endtask

	// stop sending and wait for every predicted result, plus the pipe depth
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic choose_pacing(input int mode);
		case (mode)
			0: begin send_pct = 0;  hold_pct <= 0;  end
			1: begin send_pct = 83; hold_pct <= 0;  end
			2: begin send_pct = 0;  hold_pct <= 83; end
			default: begin send_pct = 21; hold_pct <= 21; end
		endcase
	endtask

	// mostly pixels aimed at the pattern window, the rest exercises every opcode
	task automatic random_item();
		int pick;
		pick = $urandom_range(99);
		if (pick < 50)
			put_pixel(aim_x - cfg_hx + int'($urandom_range(35)) - 2,
				aim_y - cfg_hy + int'($urandom_range(35)) - 2,
				CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
		else if (pick < 58)
			put_bare(OP_PIXEL);
		else if (pick < 64)
			put_bare(OP_LOAD);
		else if (pick < 74) begin
			if ($urandom_range(3) == 0)
				put_position(OP_SET, $urandom, $urandom);
			else
				put_position(OP_SET, int'($urandom_range(cfg_w + 3)) - 2,
					int'($urandom_range(cfg_h + 3)) - 2);
		end else if (pick < 86) begin
			if ($urandom_range(4) == 0)
				put_position(OP_MOVE, $urandom, $urandom);
			else
				put_position(OP_MOVE, int'($urandom_range(80)) - 40, int'($urandom_range(80)) - 40);
		end else if (pick < 93)
			put_bare(OP_SHOW);
		else if (pick < 97)
			put_bare(OP_HIDE);
		else
			put_bare($urandom_range(1) ? OP_SPARE_A : OP_SPARE_B);
	endtask

	initial begin
		int s, mode;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setup written back explicitly: 640x480, hotspot at the corner
		write_setup(640, 480, 0, 0);

		// hidden cursor leaves the pixel alone
		put_pixel(320, 240, 8'h12, 8'h34, 8'h56);
		put_bare(OP_SHOW);
		// arrow tip is black, second row second column is white
		put_pixel(320, 240, 8'hff, 8'hff, 8'hff);
		put_pixel(321, 241, 8'h00, 8'h00, 8'h00);
		// bottom row carries all four data/mask combinations
		put_row(31, 32'haaaaaaaa, 32'hcccccccc);
		put_pixel(320, 271, 8'h00, 8'h00, 8'h00);
		put_pixel(321, 271, 8'h00, 8'h00, 8'h00);
		put_pixel(322, 271, 8'h00, 8'h7f, 8'hff);
		put_pixel(323, 271, 8'h5a, 8'ha5, 8'h3c);
		// right pattern edge and one column past it
		put_pixel(351, 271, 8'hff, 8'h80, 8'h01);
		put_pixel(352, 271, 8'hff, 8'h80, 8'h01);
		// set beyond the screen clamps to the last pixel
		put_position(OP_SET, 8191, 8191);
		// one column right of the screen edge, off screen, then the last column on screen
		put_pixel(640, 479, 8'h11, 8'h22, 8'h33);
		put_pixel(639, 479, 8'h11, 8'h22, 8'h33);
		put_position(OP_MOVE, 5, -3);
		// negative set clamps to zero
		put_position(OP_SET, -8192, -1);
		put_pixel(0, 0, 8'h80, 8'h80, 8'h80);
		// extreme deltas both ways
		put_position(OP_MOVE, 8191, -8192);
		put_position(OP_MOVE, -8192, 8191);
		put_pixel(4095, 4095, 8'hff, 8'h00, 8'hff);
		// count goes to zero and below, cursor hidden again
		put_bare(OP_HIDE);
		put_bare(OP_HIDE);
		put_pixel(0, 479, 8'h00, 8'h00, 8'h00);
		put_bare(OP_SPARE_A);
		put_bare(OP_SPARE_B);
		put_bare(OP_SHOW);
		put_bare(OP_SHOW);

		// random part: each setup under all four idle patterns
		for (s = 0; s < SETUPS; s++) begin
			settle();
			write_setup(SETUP_W[s], SETUP_H[s], SETUP_HX[s], SETUP_HY[s]);
			for (mode = 0; mode < 4; mode++) begin
				choose_pacing(mode);
				repeat (PHASE_ITEMS) random_item();
			end
		end

		settle();
		repeat (8) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: files.f
rtl/core/cov_pkg.sv
rtl/core/cov_front.sv
rtl/core/cov_queue.sv
rtl/core/cov_back.sv
rtl/core/cursor_overlay_compositor_top.sv
tb/cursor_overlay_checker.sv
tb/cursor_overlay_compositor_top_tb.sv
